// ----- rtl/core/tqst_pkg.sv -----
// Shared types, constants and helpers for the three queue service tracker.
`default_nettype none

package tqst_pkg;

    // Sizes of the queues and of the time base
    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_WIDTH  = 32;
    localparam int NUM_QUEUES  = 3;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W  = 2;
    localparam int ID_W    = 10;
    localparam int SVC_W   = 10;
    localparam int TOTAL_W = 32;
    localparam int SUM_W   = ((TIME_WIDTH > TOTAL_W) ? TIME_WIDTH : TOTAL_W) + 1;
    localparam int ENTRY_W = ID_W + TIME_WIDTH;
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_DEPTH);

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes
    localparam logic [1:0] REG_SERVICE_A = 2'd0;
    localparam logic [1:0] REG_SERVICE_B = 2'd1;
    localparam logic [1:0] REG_SERVICE_C = 2'd2;

    // Request types
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BAD_KIND = 2'd2;

    // Item kind that names no queue
    localparam logic [1:0] KIND_NONE = 2'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARRIVE,
        S_READ,
        S_EVAL
    } state_t;

    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] item_id;
        logic [1:0]      item_kind;
    } req_t;

    typedef struct packed {
        logic [1:0]         queue_index;
        logic [1:0]         status;
        logic               completed_valid;
        logic [ID_W-1:0]    completed_id;
        logic               started_valid;
        logic [ID_W-1:0]    started_id;
        logic [9:0]         remaining_ticks;
        logic [6:0]         waiting_count;
        logic [6:0]         peak_waiting;
        logic [TOTAL_W-1:0] total_wait;
        logic               all_idle;
        logic               last;
    } rsp_t;

    // Advance a ring pointer, wrapping at the queue depth
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Queue memory address of one slot
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
                                                    input logic [PTR_W-1:0] p);
        slot_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/three_queue_service_tracker.sv -----
// Top level of the three queue service tracker: sequencer, queue memory and state.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  req      | in        | req_valid / req_stall  | req_data  (tqst_pkg::req_t)
//  rsp      | out       | rsp_valid / rsp_stall  | rsp_data  (tqst_pkg::rsp_t)
//  apb      | in        | psel / penable / pready| paddr, pwdata, prdata
//
// An arrival request passes through the arrive state; a tick request, once taken, runs
// a memory read state and an evaluate state for each of the three queues in turn,
// all sharing the single read port of the queue memory.
// A result waits in the output register; a stalled output holds the sequencer only
// when it next needs to load a result. req_stall is high while a request is at work.
// Reset clears all counters, pointers and servers at once; the queue memory is not
// cleared, as the contents of a slot are used only after it has been written.
`default_nettype none

module three_queue_service_tracker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire tqst_pkg::req_t                       req_data,

    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output tqst_pkg::rsp_t                            rsp_data,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tqst_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [tqst_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tqst_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    // Sequencer and request capture
    tqst_pkg::state_t                    state_reg, state_next;
    logic [tqst_pkg::QIDX_W-1:0]         q_reg;
    logic [tqst_pkg::ID_W-1:0]           id_reg;
    logic                                bad_reg;
    logic                                end_idle_reg;

    // Per-queue state
    logic [tqst_pkg::PTR_W-1:0]          head_reg   [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::PTR_W-1:0]          tail_reg   [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::CNT_W-1:0]          cnt_reg    [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::CNT_W-1:0]          peak_reg   [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::TOTAL_W-1:0]        total_reg  [tqst_pkg::NUM_QUEUES];
    logic                                busy_reg   [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::ID_W-1:0]           item_reg   [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::TIME_WIDTH-1:0]     finish_reg [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::SVC_W-1:0]          svc_reg    [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::TIME_WIDTH-1:0]     tick_reg;

    // Queue memory
    logic [tqst_pkg::ENTRY_W-1:0]        mem [tqst_pkg::MEM_DEPTH];
    logic [tqst_pkg::ENTRY_W-1:0]        rd_reg;
    logic                                mem_we;
    logic                                mem_re;
    logic [tqst_pkg::ADDR_W-1:0]         mem_waddr;
    logic [tqst_pkg::ADDR_W-1:0]         mem_raddr;

    // Output register
    logic                                rsp_valid_reg;
    tqst_pkg::rsp_t                      rsp_reg, rsp_next;
    logic                                rsp_free;
    logic                                rsp_load;

    // Datapath for the selected queue
    logic                                req_accept;
    logic                                idle_now;
    logic                                end_idle_next;
    logic                                full;
    logic                                enqueue;
    logic [tqst_pkg::CNT_W-1:0]          cnt_inc;
    logic [tqst_pkg::CNT_W-1:0]          peak_next;
    logic                                fin;
    logic                                complete;
    logic                                start;
    logic [tqst_pkg::TIME_WIDTH-1:0]     diff;
    logic [tqst_pkg::TIME_WIDTH-1:0]     waited;
    logic [tqst_pkg::SUM_W-1:0]          sum;
    logic [tqst_pkg::TOTAL_W-1:0]        total_next;
    logic [tqst_pkg::SVC_W-1:0]          svc_eff;
    logic [tqst_pkg::ID_W-1:0]           rd_id;
    logic [tqst_pkg::TIME_WIDTH-1:0]     rd_stamp;
    logic                                tick_done;
    logic                                cfg_we;

    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_reg;
    assign rd_id      = rd_reg[tqst_pkg::ENTRY_W-1:tqst_pkg::TIME_WIDTH];
    assign rd_stamp   = rd_reg[tqst_pkg::TIME_WIDTH-1:0];

    // Look ahead over all queues: idle now, and idle once this tick is handled
    always_comb
    begin
        idle_now      = 1'b1;
        end_idle_next = 1'b1;
        for (int i = 0; i < tqst_pkg::NUM_QUEUES; i++)
        begin
            if (cnt_reg[i] != '0 || busy_reg[i])
                idle_now = 1'b0;
            if (cnt_reg[i] != '0 || (busy_reg[i] && tick_reg != finish_reg[i]))
                end_idle_next = 1'b0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tqst_pkg::S_IDLE:
            begin
                if (req_accept)
                begin
                    if (req_data.req_type == tqst_pkg::REQ_TICK)
                        state_next = tqst_pkg::S_READ;
                    else
                        state_next = tqst_pkg::S_ARRIVE;
                end
            end
            tqst_pkg::S_ARRIVE:
            begin
                if (rsp_free)
                    state_next = tqst_pkg::S_IDLE;
            end
            tqst_pkg::S_READ:
            begin
                state_next = tqst_pkg::S_EVAL;
            end
            tqst_pkg::S_EVAL:
            begin
                if (rsp_free)
                begin
                    if (q_reg == tqst_pkg::QIDX_W'(tqst_pkg::NUM_QUEUES - 1))
                        state_next = tqst_pkg::S_IDLE;
                    else
                        state_next = tqst_pkg::S_READ;
                end
            end
            default:
            begin
                state_next = tqst_pkg::S_IDLE;
            end
        endcase
    end

    // Shared arithmetic for the selected queue
    always_comb
    begin
        full      = cnt_reg[q_reg] >= tqst_pkg::CNT_W'(tqst_pkg::QUEUE_DEPTH);
        cnt_inc   = cnt_reg[q_reg] + tqst_pkg::CNT_W'(1);
        peak_next = (cnt_inc > peak_reg[q_reg]) ? cnt_inc : peak_reg[q_reg];
        fin       = tick_reg == finish_reg[q_reg];
        complete  = busy_reg[q_reg] && fin;
        start     = (!busy_reg[q_reg] || fin) && cnt_reg[q_reg] != '0;
        diff      = finish_reg[q_reg] - tick_reg;
        waited    = tick_reg - rd_stamp;
        sum       = tqst_pkg::SUM_W'(total_reg[q_reg]) + tqst_pkg::SUM_W'(waited);
        total_next = (sum > tqst_pkg::SUM_W'({tqst_pkg::TOTAL_W{1'b1}}))
                   ? {tqst_pkg::TOTAL_W{1'b1}} : sum[tqst_pkg::TOTAL_W-1:0];
        svc_eff   = (svc_reg[q_reg] == '0) ? tqst_pkg::SVC_W'(1) : svc_reg[q_reg];
    end

    // Control outputs and result assembly
    always_comb
    begin
        rsp_load  = 1'b0;
        enqueue   = 1'b0;
        tick_done = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = tqst_pkg::slot_addr(q_reg, tail_reg[q_reg]);
        mem_raddr = tqst_pkg::slot_addr(q_reg, head_reg[q_reg]);
        rsp_next  = '0;
        case (state_reg)
            tqst_pkg::S_ARRIVE:
            begin
                rsp_load = rsp_free;
                enqueue  = rsp_free && !bad_reg && !full;
                mem_we   = enqueue;
                rsp_next.last = 1'b1;
                if (bad_reg)
                begin
                    rsp_next.status   = tqst_pkg::STATUS_BAD_KIND;
                    rsp_next.all_idle = idle_now;
                end
                else if (full)
                begin
                    rsp_next.queue_index   = q_reg;
                    rsp_next.status        = tqst_pkg::STATUS_FULL;
                    rsp_next.waiting_count = 7'(cnt_reg[q_reg]);
                    rsp_next.peak_waiting  = 7'(peak_reg[q_reg]);
                    rsp_next.total_wait    = total_reg[q_reg];
                    rsp_next.all_idle      = idle_now;
                end
                else
                begin
                    rsp_next.queue_index   = q_reg;
                    rsp_next.status        = tqst_pkg::STATUS_OK;
                    rsp_next.waiting_count = 7'(cnt_inc);
                    rsp_next.peak_waiting  = 7'(peak_next);
                    rsp_next.total_wait    = total_reg[q_reg];
                    rsp_next.all_idle      = 1'b0;
                end
            end
            tqst_pkg::S_READ:
            begin
                mem_re = 1'b1;
            end
            tqst_pkg::S_EVAL:
            begin
                rsp_load  = rsp_free;
                tick_done = rsp_free
                         && q_reg == tqst_pkg::QIDX_W'(tqst_pkg::NUM_QUEUES - 1);
                rsp_next.queue_index     = q_reg;
                rsp_next.status          = tqst_pkg::STATUS_OK;
                rsp_next.completed_valid = complete;
                rsp_next.completed_id    = complete ? item_reg[q_reg] : '0;
                rsp_next.started_valid   = start;
                rsp_next.started_id      = start ? rd_id : '0;
                rsp_next.remaining_ticks = (busy_reg[q_reg] && !fin) ? 10'(diff) : '0;
                rsp_next.waiting_count   = start ? 7'(cnt_reg[q_reg] - tqst_pkg::CNT_W'(1))
                                                 : 7'(cnt_reg[q_reg]);
                rsp_next.peak_waiting    = 7'(peak_reg[q_reg]);
                rsp_next.total_wait      = start ? total_next : total_reg[q_reg];
                rsp_next.all_idle        = end_idle_reg;
                rsp_next.last            = q_reg ==
                                           tqst_pkg::QIDX_W'(tqst_pkg::NUM_QUEUES - 1);
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    // Sequencer, output register and per-queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tqst_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            tick_reg      <= '0;
            for (int i = 0; i < tqst_pkg::NUM_QUEUES; i++)
            begin
                head_reg[i]   <= '0;
                tail_reg[i]   <= '0;
                cnt_reg[i]    <= '0;
                peak_reg[i]   <= '0;
                total_reg[i]  <= '0;
                busy_reg[i]   <= 1'b0;
                item_reg[i]   <= '0;
                finish_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Hold a waiting result until it is taken
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;

            // Enqueue an arrival
            if (enqueue)
            begin
                tail_reg[q_reg] <= tqst_pkg::next_ptr(tail_reg[q_reg]);
                cnt_reg[q_reg]  <= cnt_inc;
                peak_reg[q_reg] <= peak_next;
            end

            // Start service on one queue, or release a server whose item is done
            if (state_reg == tqst_pkg::S_EVAL && rsp_free)
            begin
                if (start)
                begin
                    head_reg[q_reg]   <= tqst_pkg::next_ptr(head_reg[q_reg]);
                    cnt_reg[q_reg]    <= cnt_reg[q_reg] - tqst_pkg::CNT_W'(1);
                    total_reg[q_reg]  <= total_next;
                    busy_reg[q_reg]   <= 1'b1;
                    item_reg[q_reg]   <= rd_id;
                    finish_reg[q_reg] <= tick_reg + tqst_pkg::TIME_WIDTH'(svc_eff);
                end
                else if (complete)
                begin
                    busy_reg[q_reg] <= 1'b0;
                    item_reg[q_reg] <= '0;
                end
            end

            // Advance the tick once all queues are handled
            if (tick_done)
                tick_reg <= tick_reg + tqst_pkg::TIME_WIDTH'(1);
        end
    end

    // Capture the request; step the queue index through a tick
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            id_reg       <= req_data.item_id;
            end_idle_reg <= end_idle_next;
            if (req_data.req_type == tqst_pkg::REQ_TICK)
            begin
                q_reg   <= '0;
                bad_reg <= 1'b0;
            end
            else if (req_data.item_kind == tqst_pkg::KIND_NONE)
            begin
                q_reg   <= '0;
                bad_reg <= 1'b1;
            end
            else
            begin
                q_reg   <= req_data.item_kind - 2'd1;
                bad_reg <= 1'b0;
            end
        end
        else if (state_reg == tqst_pkg::S_EVAL && rsp_free)
        begin
            q_reg <= (q_reg == tqst_pkg::QIDX_W'(tqst_pkg::NUM_QUEUES - 1))
                   ? '0 : q_reg + tqst_pkg::QIDX_W'(1);
        end
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    // Queue memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= {id_reg, tick_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_reg <= mem[mem_raddr];
    end

    // Configuration registers
    assign cfg_we    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign req_stall = state_reg != tqst_pkg::S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tqst_pkg::NUM_QUEUES; i++)
                svc_reg[i] <= tqst_pkg::SVC_W'(1);
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                tqst_pkg::REG_SERVICE_A: svc_reg[0] <= pwdata[tqst_pkg::SVC_W-1:0];
                tqst_pkg::REG_SERVICE_B: svc_reg[1] <= pwdata[tqst_pkg::SVC_W-1:0];
                tqst_pkg::REG_SERVICE_C: svc_reg[2] <= pwdata[tqst_pkg::SVC_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (paddr[3:2])
            tqst_pkg::REG_SERVICE_A: prdata = tqst_pkg::APB_DATA_W'(svc_reg[0]);
            tqst_pkg::REG_SERVICE_B: prdata = tqst_pkg::APB_DATA_W'(svc_reg[1]);
            tqst_pkg::REG_SERVICE_C: prdata = tqst_pkg::APB_DATA_W'(svc_reg[2]);
            default:                 prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/tb_three_queue_service_tracker.sv -----
// Testbench for the three queue service tracker: predicted results checked per field.
`timescale 1ns / 1ps

module tb_three_queue_service_tracker;

    // Register index that names no register
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    tqst_pkg::req_t     req_data = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    tqst_pkg::rsp_t     rsp_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [tqst_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [tqst_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [tqst_pkg::APB_DATA_W-1:0] prdata;
    logic               pready;

    // Idling control shared by the sender and the receiver
    bit                 steady = 1'b0;
    bit                 hold_token = 1'b0;
    bit                 hold_seen = 1'b0;
    int                 hold_left = 0;

    // Predicted state of the tracker
    logic [tqst_pkg::SVC_W-1:0] svc_ticks   [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::ID_W-1:0]  slot_id     [tqst_pkg::NUM_QUEUES][tqst_pkg::QUEUE_DEPTH];
    logic [31:0]        slot_stamp  [tqst_pkg::NUM_QUEUES][tqst_pkg::QUEUE_DEPTH];
    int                 head_slot   [tqst_pkg::NUM_QUEUES];
    int                 tail_slot   [tqst_pkg::NUM_QUEUES];
    int                 queued      [tqst_pkg::NUM_QUEUES];
    int                 peak_queued [tqst_pkg::NUM_QUEUES];
    logic [31:0]        wait_sum    [tqst_pkg::NUM_QUEUES];
    bit                 busy        [tqst_pkg::NUM_QUEUES];
    logic [tqst_pkg::ID_W-1:0]  in_service  [tqst_pkg::NUM_QUEUES];
    logic [31:0]        done_tick   [tqst_pkg::NUM_QUEUES];
    logic [31:0]        tick_now;

    tqst_pkg::rsp_t     expected_results[$];
    int                 mismatch_count = 0;
    int                 result_count = 0;

    three_queue_service_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive the result stall: long hold on request, random idling otherwise
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !steady && ($urandom_range(99) < 9);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      result_count, name, got, want));
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        tqst_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none predicted",
                                          result_count));
            else
            begin
                want = expected_results.pop_front();
                check_field("queue_index", 32'(rsp_data.queue_index),
                            32'(want.queue_index));
                check_field("status", 32'(rsp_data.status), 32'(want.status));
                check_field("completed_valid", 32'(rsp_data.completed_valid),
                            32'(want.completed_valid));
                check_field("completed_id", 32'(rsp_data.completed_id),
                            32'(want.completed_id));
                check_field("started_valid", 32'(rsp_data.started_valid),
                            32'(want.started_valid));
                check_field("started_id", 32'(rsp_data.started_id),
                            32'(want.started_id));
                check_field("remaining_ticks", 32'(rsp_data.remaining_ticks),
                            32'(want.remaining_ticks));
                check_field("waiting_count", 32'(rsp_data.waiting_count),
                            32'(want.waiting_count));
                check_field("peak_waiting", 32'(rsp_data.peak_waiting),
                            32'(want.peak_waiting));
                check_field("total_wait", rsp_data.total_wait, want.total_wait);
                check_field("all_idle", 32'(rsp_data.all_idle), 32'(want.all_idle));
                check_field("last", 32'(rsp_data.last), 32'(want.last));
            end
            result_count++;
        end
    end

    function automatic bit tracker_idle();
        for (int q = 0; q < tqst_pkg::NUM_QUEUES; q++)
            if (queued[q] != 0 || busy[q])
                return 1'b0;
        return 1'b1;
    endfunction

    // Occupancy fields of one queue, everything else cleared
    function automatic tqst_pkg::rsp_t queue_view(input int q);
        tqst_pkg::rsp_t r;
        r = '0;
        r.queue_index   = q[1:0];
        r.waiting_count = queued[q][6:0];
        r.peak_waiting  = peak_queued[q][6:0];
        r.total_wait    = wait_sum[q];
        return r;
    endfunction

    // Advance the predicted state by one accepted request and queue its results
    task automatic track_request(input tqst_pkg::req_t r);
        tqst_pkg::rsp_t res [tqst_pkg::NUM_QUEUES];
        int          q;
        bit          cv, sv, idle;
        logic [9:0]  cid, sid, rem;
        logic [31:0] waited, gap;
        logic [32:0] sum;
        logic [9:0]  st;
        if (r.req_type == tqst_pkg::REQ_ARRIVAL)
        begin
            res[0] = '0;
            if (r.item_kind == tqst_pkg::KIND_NONE)
                res[0].status = tqst_pkg::STATUS_BAD_KIND;
            else
            begin
                q = int'(r.item_kind) - 1;
                if (queued[q] >= tqst_pkg::QUEUE_DEPTH)
                begin
                    res[0] = queue_view(q);
                    res[0].status = tqst_pkg::STATUS_FULL;
                end
                else
                begin
                    slot_id[q][tail_slot[q]]    = r.item_id;
                    slot_stamp[q][tail_slot[q]] = tick_now;
                    tail_slot[q] = (tail_slot[q] + 1) % tqst_pkg::QUEUE_DEPTH;
                    queued[q]++;
                    if (queued[q] > peak_queued[q])
                        peak_queued[q] = queued[q];
                    res[0] = queue_view(q);
                    res[0].status = tqst_pkg::STATUS_OK;
                end
            end
            res[0].all_idle = tracker_idle();
            res[0].last = 1'b1;
            expected_results.push_back(res[0]);
        end
        else
        begin
            for (q = 0; q < tqst_pkg::NUM_QUEUES; q++)
            begin
                cv = 1'b0; cid = '0; sv = 1'b0; sid = '0; rem = '0;
                // Complete the item in service, or report the ticks it still needs
                if (busy[q])
                begin
                    if (tick_now == done_tick[q])
                    begin
                        cv = 1'b1;
                        cid = in_service[q];
                        busy[q] = 1'b0;
                        in_service[q] = '0;
                    end
                    else
                    begin
                        gap = done_tick[q] - tick_now;
                        rem = gap[9:0];
                    end
                end
                // Start the head item on an idle server
                if (!busy[q] && queued[q] != 0)
                begin
                    waited = tick_now - slot_stamp[q][head_slot[q]];
                    sum = {1'b0, wait_sum[q]} + {1'b0, waited};
                    wait_sum[q] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    st = (svc_ticks[q] == '0) ? 10'd1 : svc_ticks[q];
                    sid = slot_id[q][head_slot[q]];
                    sv = 1'b1;
                    head_slot[q] = (head_slot[q] + 1) % tqst_pkg::QUEUE_DEPTH;
                    queued[q]--;
                    busy[q] = 1'b1;
                    in_service[q] = sid;
                    done_tick[q] = tick_now + 32'(st);
                end
                res[q] = queue_view(q);
                res[q].completed_valid = cv;
                res[q].completed_id    = cid;
                res[q].started_valid   = sv;
                res[q].started_id      = sid;
                res[q].remaining_ticks = rem;
            end
            idle = tracker_idle();
            for (q = 0; q < tqst_pkg::NUM_QUEUES; q++)
            begin
                res[q].all_idle = idle;
                res[q].last = (q == tqst_pkg::NUM_QUEUES - 1);
                expected_results.push_back(res[q]);
            end
            tick_now = tick_now + 32'd1;
        end
    endtask

    function automatic tqst_pkg::req_t make_request(input logic kind_of_req,
                                                    input logic [9:0] id,
                                                    input logic [1:0] kind);
        tqst_pkg::req_t r;
        r.req_type  = kind_of_req;
        r.item_id   = id;
        r.item_kind = kind;
        return r;
    endfunction

    function automatic tqst_pkg::req_t random_request(input int tick_pct);
        logic [1:0] kind;
        kind = ($urandom_range(99) < 8) ? tqst_pkg::KIND_NONE : 2'($urandom_range(3, 1));
        return make_request(($urandom_range(99) < tick_pct) ? tqst_pkg::REQ_TICK
                                                            : tqst_pkg::REQ_ARRIVAL,
                            10'($urandom_range(1023)), kind);
    endfunction

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input tqst_pkg::req_t r);
        int gap;
        gap = (!steady && $urandom_range(99) < 9) ? $urandom_range(6, 1) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (!req_valid)
            req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (req_stall);
        track_request(r);
    endtask

    // Stop offering requests until every predicted result has come
    task automatic settle();
        int waited;
        req_valid <= 1'b0;
        for (waited = 0; waited < 5000 && expected_results.size() != 0; waited++)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write one service time register through the configuration port
    task automatic write_service(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx != REG_SPARE)
            svc_ticks[idx] = value[tqst_pkg::SVC_W-1:0];
    endtask

    task automatic test_directed();
        // A tick on an empty block, a bad kind, arrivals in every queue with edge ids in the first two, then ticks
        send_request(make_request(tqst_pkg::REQ_TICK, 10'd0, tqst_pkg::KIND_NONE));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h3FF, tqst_pkg::KIND_NONE));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h000, 2'd1));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h3FF, 2'd2));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h155, 2'd3));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h2AA, 2'd3));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h3FF, 2'd1));
        send_request(make_request(tqst_pkg::REQ_TICK, 10'h3FF, 2'd3));
        send_request(make_request(tqst_pkg::REQ_TICK, 10'h000, 2'd0));
        settle();
        // Zero service time, masked upper bits and a write to no register
        write_service(tqst_pkg::REG_SERVICE_A, 32'd0);
        write_service(tqst_pkg::REG_SERVICE_B, 32'd2);
        write_service(tqst_pkg::REG_SERVICE_C, 32'hABCD_FC01);
        write_service(REG_SPARE, 32'd7);
        send_request(make_request(tqst_pkg::REQ_TICK, 10'h155, 2'd2));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h200, 2'd2));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h1FF, 2'd2));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h000, tqst_pkg::KIND_NONE));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'h001, 2'd1));
        for (int i = 0; i < 5; i++)
            send_request(make_request(tqst_pkg::REQ_TICK, 10'($urandom_range(1023)),
                                      2'($urandom_range(3))));
        settle();
    endtask

    task automatic test_queue_full();
        // Hold the results back while one queue overflows
        hold_token <= ~hold_token;
        for (int i = 0; i < 70; i++)
            send_request(make_request(tqst_pkg::REQ_ARRIVAL,
                                      10'($urandom_range(1023)), 2'd2));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'($urandom_range(1023)), 2'd1));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'($urandom_range(1023)), 2'd3));
        settle();
    endtask

    task automatic test_random_mix();
        write_service(tqst_pkg::REG_SERVICE_A, 32'd3);
        write_service(tqst_pkg::REG_SERVICE_B, 32'd1);
        write_service(tqst_pkg::REG_SERVICE_C, 32'd5);
        for (int i = 0; i < 110; i++)
            send_request(random_request(40));
        settle();
    endtask

    task automatic test_steady_flow();
        write_service(tqst_pkg::REG_SERVICE_A, 32'($urandom_range(8, 1)));
        write_service(tqst_pkg::REG_SERVICE_B, 32'($urandom_range(8, 1)));
        write_service(tqst_pkg::REG_SERVICE_C, 32'($urandom_range(8, 1)));
        steady <= 1'b1;
        for (int i = 0; i < 100; i++)
            send_request(random_request(45));
        steady <= 1'b0;
        settle();
    endtask

    task automatic test_long_service();
        write_service(tqst_pkg::REG_SERVICE_A, 32'd1023);
        write_service(tqst_pkg::REG_SERVICE_B, 32'hFFFF_FFFF);
        write_service(tqst_pkg::REG_SERVICE_C, 32'd1);
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'($urandom_range(1023)), 2'd1));
        send_request(make_request(tqst_pkg::REQ_ARRIVAL, 10'($urandom_range(1023)), 2'd2));
        for (int i = 0; i < 10; i++)
            send_request(make_request(tqst_pkg::REQ_TICK, 10'($urandom_range(1023)),
                                      2'($urandom_range(3))));
        settle();
    endtask

    initial
    begin
        for (int q = 0; q < tqst_pkg::NUM_QUEUES; q++)
        begin
            svc_ticks[q]   = 10'd1;
            head_slot[q]   = 0;
            tail_slot[q]   = 0;
            queued[q]      = 0;
            peak_queued[q] = 0;
            wait_sum[q]    = '0;
            busy[q]        = 1'b0;
            in_service[q]  = '0;
            done_tick[q]   = '0;
        end
        tick_now = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_queue_full();
        test_random_mix();
        test_steady_flow();
        test_long_service();

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_results.size()));
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
